// File: sv/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared widths, payload types and codes of the segment/triangle test.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int CB    = 20;
    localparam int WF    = 16;
    localparam int WW    = WF + 1;
    localparam int DIFW  = CB + 1;
    localparam int CRW   = 2 * DIFW + 1;
    localparam int DOTW  = CRW + DIFW + 2;
    localparam int RW    = DOTW + 1;
    localparam int MW    = (CB > WW) ? CB : WW;
    localparam int KW    = MW + 2;
    localparam int REG_W = 3 * CB;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;
    localparam int FRONT_LAT = 5;
    localparam int LATENCY = FRONT_LAT + MW + 1;
    localparam int COORD_MAX = (1 << (CB - 1)) - 1;
    localparam int COORD_MIN = -(1 << (CB - 1));

    localparam logic [1:0] ST_DISJOINT   = 2'd0;
    localparam logic [1:0] ST_HIT        = 2'd1;
    localparam logic [1:0] ST_COPLANAR   = 2'd2;
    localparam logic [1:0] ST_DEGENERATE = 2'd3;

    localparam logic [1:0] REG_VERTEX_A = 2'd0;
    localparam logic [1:0] REG_VERTEX_B = 2'd1;
    localparam logic [1:0] REG_VERTEX_C = 2'd2;

    typedef logic signed [CB-1:0]   coord_t;
    typedef logic [WW-1:0]          weight_t;
    typedef logic signed [DIFW-1:0] dif_t;
    typedef logic signed [CRW-1:0]  crs_t;
    typedef logic signed [DOTW-1:0] dot_t;
    typedef logic [MW-1:0]          mag_t;

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_start_z;
        coord_t seg_end_x;
        coord_t seg_end_y;
        coord_t seg_end_z;
    } req_t;

    typedef struct packed {
        logic [1:0] hit_status;
        weight_t    seg_param;
        coord_t     hit_x;
        coord_t     hit_y;
        coord_t     hit_z;
        weight_t    bary_w0;
        weight_t    bary_w1;
        weight_t    bary_w2;
    } rsp_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [DOTW-1:0] xa;
        logic [DOTW-1:0] xs;
        logic [DOTW-1:0] xt;
        logic [DOTW-1:0] b;
        coord_t          px;
        coord_t          py;
        coord_t          pz;
        logic [2:0]      dneg;
        mag_t            dmx;
        mag_t            dmy;
        mag_t            dmz;
    } front_t;

    typedef struct packed {
        logic [1:0] status;
        coord_t     px;
        coord_t     py;
        coord_t     pz;
        logic [2:0] dneg;
    } side_t;

endpackage

// File: sv/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect
// Exact fixed-point test of a 3D segment against a configured triangle.
// ----------------------------------------------------------------------------
// The triangle vertices are written through the APB port at byte addresses
// 0, 8 and 16, each as three signed coordinates with x in the low bits.
// Write them only while no request is in flight.
// A request is taken at every clock edge where start is high; busy stays low,
// so a new request may enter in every cycle.
// Each request yields one result, shown on result for exactly one cycle with
// result_valid high. It passes through the geometry pipeline, the scaled
// divider pipeline (one quotient bit per stage) and the output register.
// Results leave in request order. The receiver cannot stall the block.
// Reset clears the vertices to zero and drops every request in flight.
// ----------------------------------------------------------------------------
module segment_triangle_intersect (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stq_pkg::ADDR_W-1:0]   paddr,
    input  logic [stq_pkg::DATA_W-1:0]   pwdata,
    output logic [stq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  stq_pkg::req_t                request,
    output logic                         result_valid,
    output stq_pkg::rsp_t                result
);
    import stq_pkg::*;

    localparam mag_t    ONE_M  = mag_t'(1) << WF;
    localparam weight_t ONE_WT = weight_t'(1) << WF;

    function automatic coord_t coord_fix(input coord_t p, input logic neg,
                                         input mag_t qd, input logic rnz);
        logic signed [KW-1:0] k;
        logic signed [KW-1:0] qe;
        qe = signed'({2'b00, qd});
        k  = KW'(p) + (neg ? -qe : qe);
        if (rnz && !neg && k < 0)
        begin
            k = k + KW'(1);
        end
        else if (rnz && neg && k > 0)
        begin
            k = k - KW'(1);
        end
        if (k > KW'(COORD_MAX))
        begin
            return coord_t'(COORD_MAX);
        end
        else if (k < KW'(COORD_MIN))
        begin
            return coord_t'(COORD_MIN);
        end
        return coord_t'(k);
    endfunction

    logic [REG_W-1:0] vert_reg [3];
    logic             fr_valid;
    front_t           fr;
    side_t            side_reg [MW];
    logic             dv [6];
    mag_t             dq [6];
    logic             dr [6];
    logic             result_valid_reg;
    rsp_t             result_reg;
    rsp_t             result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_reg[0] <= '0;
            vert_reg[1] <= '0;
            vert_reg[2] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_VERTEX_A: vert_reg[0] <= pwdata[REG_W-1:0];
                REG_VERTEX_B: vert_reg[1] <= pwdata[REG_W-1:0];
                REG_VERTEX_C: vert_reg[2] <= pwdata[REG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_VERTEX_A: prdata = DATA_W'(vert_reg[0]);
            REG_VERTEX_B: prdata = DATA_W'(vert_reg[1]);
            REG_VERTEX_C: prdata = DATA_W'(vert_reg[2]);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    stq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .req       (request),
        .vert_a    (vert_reg[0]),
        .vert_b    (vert_reg[1]),
        .vert_c    (vert_reg[2]),
        .out_valid (fr_valid),
        .out       (fr)
    );

    stq_muldiv u_div_r (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xa),
        .b(fr.b), .m(ONE_M), .out_valid(dv[0]), .q(dq[0]), .rem_nz(dr[0]));
    stq_muldiv u_div_s (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xs),
        .b(fr.b), .m(ONE_M), .out_valid(dv[1]), .q(dq[1]), .rem_nz(dr[1]));
    stq_muldiv u_div_t (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xt),
        .b(fr.b), .m(ONE_M), .out_valid(dv[2]), .q(dq[2]), .rem_nz(dr[2]));
    stq_muldiv u_div_x (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xa),
        .b(fr.b), .m(fr.dmx), .out_valid(dv[3]), .q(dq[3]), .rem_nz(dr[3]));
    stq_muldiv u_div_y (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xa),
        .b(fr.b), .m(fr.dmy), .out_valid(dv[4]), .q(dq[4]), .rem_nz(dr[4]));
    stq_muldiv u_div_z (.clk(clk), .rst_n(rst_n), .in_valid(fr_valid), .x(fr.xa),
        .b(fr.b), .m(fr.dmz), .out_valid(dv[5]), .q(dq[5]), .rem_nz(dr[5]));

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{status: fr.status, px: fr.px, py: fr.py, pz: fr.pz,
                         dneg: fr.dneg};
        for (int i = 1; i < MW; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        side_t sd;
        sd = side_reg[MW-1];
        result_next = '0;
        result_next.hit_status = sd.status;
        if (sd.status == ST_HIT)
        begin
            result_next.seg_param = weight_t'(dq[0]);
            result_next.bary_w1   = weight_t'(dq[1]);
            result_next.bary_w2   = weight_t'(dq[2]);
            result_next.bary_w0   = ONE_WT - weight_t'(dq[1]) - weight_t'(dq[2]);
            result_next.hit_x     = coord_fix(sd.px, sd.dneg[0], dq[3], dr[3]);
            result_next.hit_y     = coord_fix(sd.py, sd.dneg[1], dq[4], dr[4]);
            result_next.hit_z     = coord_fix(sd.pz, sd.dneg[2], dq[5], dr[5]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= dv[0] && dv[1] && dv[2] && dv[3] && dv[4] && dv[5];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/stq_front.sv
// ----------------------------------------------------------------------------
// stq_front
// Five-stage geometry pipeline: edges, cross products, dot products,
// orientation fix and the exact hit decision on numerators.
// ----------------------------------------------------------------------------
module stq_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  stq_pkg::req_t               req,
    input  logic [stq_pkg::REG_W-1:0]   vert_a,
    input  logic [stq_pkg::REG_W-1:0]   vert_b,
    input  logic [stq_pkg::REG_W-1:0]   vert_c,
    output logic                        out_valid,
    output stq_pkg::front_t             out
);
    import stq_pkg::*;

    function automatic crs_t xp(input dif_t a1, input dif_t b1, input dif_t a2,
                                input dif_t b2);
        crs_t p1;
        crs_t p2;
        p1 = a1 * b1;
        p2 = a2 * b2;
        return p1 - p2;
    endfunction

    function automatic dot_t dot(input crs_t x0, input crs_t x1, input crs_t x2,
                                 input dif_t y0, input dif_t y1, input dif_t y2);
        dot_t t0;
        dot_t t1;
        dot_t t2;
        t0 = x0 * y0;
        t1 = x1 * y1;
        t2 = x2 * y2;
        return t0 + t1 + t2;
    endfunction

    coord_t va [3];
    coord_t vb [3];
    coord_t vc [3];
    coord_t pp [3];
    coord_t qq [3];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    dif_t   u1_reg [3];
    dif_t   e1_reg [3];
    dif_t   w1_reg [3];
    dif_t   d1_reg [3];
    coord_t p1_reg [3];

    crs_t   n2_reg [3];
    crs_t   m2_reg [3];
    crs_t   k2_reg [3];
    dif_t   w2_reg [3];
    dif_t   d2_reg [3];
    coord_t p2_reg [3];

    dot_t   a3_reg, b3_reg, s3_reg, t3_reg;
    logic   dg3_reg;
    dif_t   d3_reg [3];
    coord_t p3_reg [3];

    dot_t   a4_reg, b4_reg, s4_reg, t4_reg;
    logic   dg4_reg, bz4_reg, az4_reg;
    dif_t   d4_reg [3];
    coord_t p4_reg [3];

    front_t out_next;
    front_t out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va[k] = coord_t'(vert_a[k*CB +: CB]);
            vb[k] = coord_t'(vert_b[k*CB +: CB]);
            vc[k] = coord_t'(vert_c[k*CB +: CB]);
        end
        pp[0] = req.seg_start_x;
        pp[1] = req.seg_start_y;
        pp[2] = req.seg_start_z;
        qq[0] = req.seg_end_x;
        qq[1] = req.seg_end_y;
        qq[2] = req.seg_end_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            u1_reg[k] <= dif_t'(vb[k]) - dif_t'(va[k]);
            e1_reg[k] <= dif_t'(vc[k]) - dif_t'(va[k]);
            w1_reg[k] <= dif_t'(pp[k]) - dif_t'(va[k]);
            d1_reg[k] <= dif_t'(qq[k]) - dif_t'(pp[k]);
            p1_reg[k] <= pp[k];
        end

        n2_reg[0] <= xp(u1_reg[1], e1_reg[2], u1_reg[2], e1_reg[1]);
        n2_reg[1] <= xp(u1_reg[2], e1_reg[0], u1_reg[0], e1_reg[2]);
        n2_reg[2] <= xp(u1_reg[0], e1_reg[1], u1_reg[1], e1_reg[0]);
        m2_reg[0] <= xp(w1_reg[1], e1_reg[2], w1_reg[2], e1_reg[1]);
        m2_reg[1] <= xp(w1_reg[2], e1_reg[0], w1_reg[0], e1_reg[2]);
        m2_reg[2] <= xp(w1_reg[0], e1_reg[1], w1_reg[1], e1_reg[0]);
        k2_reg[0] <= xp(u1_reg[1], w1_reg[2], u1_reg[2], w1_reg[1]);
        k2_reg[1] <= xp(u1_reg[2], w1_reg[0], u1_reg[0], w1_reg[2]);
        k2_reg[2] <= xp(u1_reg[0], w1_reg[1], u1_reg[1], w1_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            w2_reg[k] <= w1_reg[k];
            d2_reg[k] <= d1_reg[k];
            p2_reg[k] <= p1_reg[k];
        end

        a3_reg <= -dot(n2_reg[0], n2_reg[1], n2_reg[2], w2_reg[0], w2_reg[1], w2_reg[2]);
        b3_reg <= dot(n2_reg[0], n2_reg[1], n2_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]);
        s3_reg <= dot(m2_reg[0], m2_reg[1], m2_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]);
        t3_reg <= dot(k2_reg[0], k2_reg[1], k2_reg[2], d2_reg[0], d2_reg[1], d2_reg[2]);
        dg3_reg <= (n2_reg[0] == '0) && (n2_reg[1] == '0) && (n2_reg[2] == '0);
        for (int k = 0; k < 3; k++)
        begin
            d3_reg[k] <= d2_reg[k];
            p3_reg[k] <= p2_reg[k];
        end

        a4_reg  <= b3_reg[DOTW-1] ? -a3_reg : a3_reg;
        b4_reg  <= b3_reg[DOTW-1] ? -b3_reg : b3_reg;
        s4_reg  <= b3_reg[DOTW-1] ? -s3_reg : s3_reg;
        t4_reg  <= b3_reg[DOTW-1] ? -t3_reg : t3_reg;
        dg4_reg <= dg3_reg;
        bz4_reg <= (b3_reg == '0);
        az4_reg <= (a3_reg == '0);
        for (int k = 0; k < 3; k++)
        begin
            d4_reg[k] <= d3_reg[k];
            p4_reg[k] <= p3_reg[k];
        end

        out_reg <= out_next;
    end

    always_comb
    begin
        logic signed [DOTW:0] st_sum;
        logic signed [DOTW:0] b_ext;
        logic                 hit;
        dif_t                 dm [3];
        st_sum = (DOTW+1)'(s4_reg) + (DOTW+1)'(t4_reg);
        b_ext  = (DOTW+1)'(b4_reg);
        hit = !(a4_reg < 0 || a4_reg > b4_reg || s4_reg < 0 || s4_reg > b4_reg ||
                t4_reg < 0 || st_sum > b_ext);
        for (int k = 0; k < 3; k++)
        begin
            dm[k] = d4_reg[k][DIFW-1] ? -d4_reg[k] : d4_reg[k];
        end
        if (dg4_reg)
        begin
            out_next.status = ST_DEGENERATE;
        end
        else if (bz4_reg)
        begin
            out_next.status = az4_reg ? ST_COPLANAR : ST_DISJOINT;
        end
        else
        begin
            out_next.status = hit ? ST_HIT : ST_DISJOINT;
        end
        if (out_next.status == ST_HIT)
        begin
            out_next.xa = a4_reg;
            out_next.xs = s4_reg;
            out_next.xt = t4_reg;
        end
        else
        begin
            out_next.xa = '0;
            out_next.xs = '0;
            out_next.xt = '0;
        end
        out_next.b    = b4_reg;
        out_next.px   = p4_reg[0];
        out_next.py   = p4_reg[1];
        out_next.pz   = p4_reg[2];
        out_next.dneg = {d4_reg[2][DIFW-1], d4_reg[1][DIFW-1], d4_reg[0][DIFW-1]};
        out_next.dmx  = mag_t'(dm[0]);
        out_next.dmy  = mag_t'(dm[1]);
        out_next.dmz  = mag_t'(dm[2]);
    end

    assign out_valid = v5_reg;
    assign out       = out_reg;

endmodule

// File: sv/stq_muldiv.sv
// ----------------------------------------------------------------------------
// stq_muldiv
// Pipelined scaled divider: floor(x * m / b) for 0 <= x <= b, one
// multiplier bit per stage with a radix-2 digit in the range zero to two.
// ----------------------------------------------------------------------------
module stq_muldiv (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [stq_pkg::DOTW-1:0]    x,
    input  logic [stq_pkg::DOTW-1:0]    b,
    input  stq_pkg::mag_t               m,
    output logic                        out_valid,
    output stq_pkg::mag_t               q,
    output logic                        rem_nz
);
    import stq_pkg::*;

    logic            vld_reg [MW];
    logic [RW-1:0]   rem_reg [MW];
    logic [RW-1:0]   x_reg   [MW];
    logic [RW-1:0]   b_reg   [MW];
    mag_t            m_reg   [MW];
    mag_t            q_reg   [MW];

    logic [RW-1:0]   rem_in  [MW];
    logic [RW-1:0]   x_in    [MW];
    logic [RW-1:0]   b_in    [MW];
    mag_t            m_in    [MW];
    mag_t            q_in    [MW];
    logic            vld_in  [MW];
    logic [RW-1:0]   rem_next [MW];
    mag_t            q_next   [MW];

    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            logic [RW-1:0] t;
            logic [RW-1:0] b2;
            if (i == 0)
            begin
                vld_in[i] = in_valid;
                rem_in[i] = '0;
                x_in[i]   = RW'(x);
                b_in[i]   = RW'(b);
                m_in[i]   = m;
                q_in[i]   = '0;
            end
            else
            begin
                vld_in[i] = vld_reg[i-1];
                rem_in[i] = rem_reg[i-1];
                x_in[i]   = x_reg[i-1];
                b_in[i]   = b_reg[i-1];
                m_in[i]   = m_reg[i-1];
                q_in[i]   = q_reg[i-1];
            end
            t  = {rem_in[i][RW-2:0], 1'b0} + (m_in[i][MW-1-i] ? x_in[i] : '0);
            b2 = {b_in[i][RW-2:0], 1'b0};
            if (t >= b2)
            begin
                rem_next[i] = t - b2;
                q_next[i]   = {q_in[i][MW-2:0], 1'b0} + mag_t'(2);
            end
            else if (t >= b_in[i])
            begin
                rem_next[i] = t - b_in[i];
                q_next[i]   = {q_in[i][MW-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t;
                q_next[i]   = {q_in[i][MW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MW; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < MW; i++)
            begin
                vld_reg[i] <= vld_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MW; i++)
        begin
            rem_reg[i] <= rem_next[i];
            x_reg[i]   <= x_in[i];
            b_reg[i]   <= b_in[i];
            m_reg[i]   <= m_in[i];
            q_reg[i]   <= q_next[i];
        end
    end

    assign out_valid = vld_reg[MW-1];
    assign q         = q_reg[MW-1];
    assign rem_nz    = |rem_reg[MW-1];

endmodule

// File: sv/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of request latency and result consistency.
// ----------------------------------------------------------------------------
module stq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          result_valid,
    input stq_pkg::rsp_t result
);
    import stq_pkg::*;

    a_latency_in: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LATENCY) result_valid)
        else $error("request produced no result at the expected latency");

    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_status != ST_HIT) |->
        (result.seg_param == '0 && result.hit_x == '0 && result.hit_y == '0 &&
         result.hit_z == '0 && result.bary_w0 == '0 && result.bary_w1 == '0 &&
         result.bary_w2 == '0))
        else $error("non-hit result carries nonzero fields");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit_status == ST_HIT) |->
        ((WW+2)'(result.bary_w0) + (WW+2)'(result.bary_w1) +
         (WW+2)'(result.bary_w2) == (WW+2)'(1) << WF))
        else $error("barycentric weights do not sum to one");

endmodule

bind segment_triangle_intersect stq_checker u_stq_checker (.*);
